// ===== hw/rtl/amd_pkg.sv =====
package amd_pkg;

   // Field and register widths
   localparam int WIDTH_W       = 11;   // src_width register
   localparam int HEIGHT_W      = 16;   // src_height register
   localparam int PIX_W         = 8;    // one colour or alpha channel
   localparam int PA_W          = 9;    // horizontal pair alpha sum
   localparam int PC_W          = 17;   // horizontal pair premultiplied colour sum
   localparam int TA_W          = 10;   // 2x2 block alpha sum
   localparam int TC_W          = 18;   // 2x2 block colour sum plus rounding term
   localparam int ENTRY_W       = PA_W + 3 * PC_W;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;

   // Defaults
   localparam int MAX_WIDTH_DEF = 1024;
   localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd256;
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 16'd256;

   // Register indexes (address bit 2)
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // One RGBA8 pixel, red in the lowest byte
   typedef struct packed {
      logic [PIX_W-1:0] a;
      logic [PIX_W-1:0] b;
      logic [PIX_W-1:0] g;
      logic [PIX_W-1:0] r;
   } pixel_type;

   // Line store entry: horizontal pair sums of a block's top row
   typedef struct packed {
      logic [PC_W-1:0] pb;
      logic [PC_W-1:0] pg;
      logic [PC_W-1:0] pr;
      logic [PA_W-1:0] pa;
   } pair_type;

   // What a pixel does once its pair is formed
   typedef enum logic [1:0] {
      JOB_NONE,     // left pixel or dropped column/row
      JOB_WRITE,    // top row pair: write line store
      JOB_READ,     // bottom row pair: read line store and emit
      JOB_DIRECT    // single-row image: use the pair twice and emit
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAIR,
      ST_MERGE,
      ST_DIV
   } state_type;

   // Divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== hw/rtl/alpha_weighted_mip_downsample.sv =====
// A pixel that completes a 2x2 block gives its output pixel after the pair sums, the line store
//    read, the 8-step shared quotient unit and the output register, in that order.
// The block takes a new source pixel only once it is through with the last one; for a pixel
//    that completes a block, the 8 iterations of the quotient unit set the pace.
// Reset (synchronous, active high) clears counters, held pixel and control, and restores
//    the default registers; the line store is not cleared and needs no clearing pass.
module alpha_weighted_mip_downsample #(
   parameter int MAX_WIDTH = amd_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // source pixels
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,   // red_in, green_in, blue_in, alpha_in
   // downsampled pixels
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,   // red_out, green_out, blue_out, alpha_out
   output logic                            rsp_tlast,   // frame_end
   // configuration
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [amd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [amd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [amd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int DEPTH  = MAX_WIDTH / 2;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WW     = amd_pkg::WIDTH_W;
   localparam int HW     = amd_pkg::HEIGHT_W;

   amd_pkg::state_type            state_ff, state_in;
   logic [WW-1:0]                 width_ff;
   logic [HW-1:0]                 height_ff;
   logic [WW-1:0]                 col_ff;
   logic [HW-1:0]                 row_ff;
   amd_pkg::pixel_type            held_ff;
   amd_pkg::pixel_type            pix_ff;
   amd_pkg::job_type              job_ff, job_in;
   logic                          w1_ff;
   logic [ADDR_W-1:0]             addr_ff;
   logic                          last_ff, last_in;
   amd_pkg::pair_type             pair_ff, pair_cur, top_sel;
   logic                          rsp_valid_ff;
   amd_pkg::pixel_type            rsp_data_ff;
   logic                          rsp_last_ff;
   logic                          zero_ff;
   logic [amd_pkg::PIX_W-1:0]     alpha_ff;

   logic [WW-1:0]                 w_eff, ow_eff, x_cur, x_nxt, ox;
   logic [HW-1:0]                 h_eff, oh_eff, y_cur, y_nxt, oy;
   logic [WW+ADDR_W-1:0]          ox_ext;
   logic                          w_is_one, h_is_one, col_ok, capture;
   logic                          accept, csr_wr, load_out;
   logic                          ram_we, ram_re, div_start;
   logic [amd_pkg::ENTRY_W-1:0]   ram_rdata;
   logic [amd_pkg::TA_W-1:0]      ta;
   logic [amd_pkg::TA_W-1:0]      ta_round;
   logic [2:0][amd_pkg::TC_W-1:0] num;
   logic [2:0][amd_pkg::PIX_W-1:0] quo;
   amd_pkg::div_stat_type         div_stat;
   logic [15:0]                   p_r, p_g, p_b, lp_r, lp_g, lp_b;

   assign accept     = req_tvalid && req_tready;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Register read
   always_comb begin
      unique case (csr_paddr[2])
         amd_pkg::REG_WIDTH:  csr_prdata = amd_pkg::CSR_DATA_W'(width_ff);
         amd_pkg::REG_HEIGHT: csr_prdata = amd_pkg::CSR_DATA_W'(height_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // Effective geometry and position of the incoming pixel
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff    = (height_ff == '0) ? HW'(1) : height_ff;
      w_is_one = w_eff == WW'(1);
      h_is_one = h_eff == HW'(1);
      ow_eff   = ((w_eff >> 1) == '0) ? WW'(1) : (w_eff >> 1);
      oh_eff   = ((h_eff >> 1) == '0) ? HW'(1) : (h_eff >> 1);
      x_cur    = (col_ff >= w_eff) ? '0 : col_ff;
      y_cur    = (row_ff >= h_eff) ? '0 : row_ff;
      ox       = w_is_one ? '0 : (x_cur >> 1);
      oy       = h_is_one ? '0 : (y_cur >> 1);
      ox_ext   = {{ADDR_W{1'b0}}, ox};
      col_ok   = !w_is_one && (ox < ow_eff);
      capture  = col_ok && !x_cur[0];

      // next position, wrapping at the end of a row and of the frame
      x_nxt = x_cur + WW'(1);
      y_nxt = y_cur;
      if (x_nxt >= w_eff) begin
         x_nxt = '0;
         y_nxt = y_cur + HW'(1);
         if (y_nxt >= h_eff) begin
            y_nxt = '0;
         end
      end

      // role of this pixel
      job_in = amd_pkg::JOB_NONE;
      if (w_is_one || (col_ok && x_cur[0])) begin
         if (h_is_one) begin
            job_in = amd_pkg::JOB_DIRECT;
         end else if (oy < oh_eff) begin
            job_in = y_cur[0] ? amd_pkg::JOB_READ : amd_pkg::JOB_WRITE;
         end
      end
      last_in = (ox == ow_eff - WW'(1)) && (oy == oh_eff - HW'(1));
   end

   // Horizontal pair sums from the held left pixel and the current one (current pixel doubled for width one)
   always_comb begin
      p_r  = 16'(pix_ff.r) * 16'(pix_ff.a);
      p_g  = 16'(pix_ff.g) * 16'(pix_ff.a);
      p_b  = 16'(pix_ff.b) * 16'(pix_ff.a);
      lp_r = 16'(held_ff.r) * 16'(held_ff.a);
      lp_g = 16'(held_ff.g) * 16'(held_ff.a);
      lp_b = 16'(held_ff.b) * 16'(held_ff.a);
      if (w1_ff) begin
         pair_cur.pa = {1'b0, pix_ff.a} << 1;
         pair_cur.pr = {p_r, 1'b0};
         pair_cur.pg = {p_g, 1'b0};
         pair_cur.pb = {p_b, 1'b0};
      end else begin
         pair_cur.pa = amd_pkg::PA_W'(held_ff.a) + amd_pkg::PA_W'(pix_ff.a);
         pair_cur.pr = amd_pkg::PC_W'(lp_r) + amd_pkg::PC_W'(p_r);
         pair_cur.pg = amd_pkg::PC_W'(lp_g) + amd_pkg::PC_W'(p_g);
         pair_cur.pb = amd_pkg::PC_W'(lp_b) + amd_pkg::PC_W'(p_b);
      end
   end

   // Block totals: top row from the line store, or the same pair again for one row
   always_comb begin
      top_sel  = (job_ff == amd_pkg::JOB_READ) ? amd_pkg::pair_type'(ram_rdata) : pair_ff;
      ta       = amd_pkg::TA_W'(pair_ff.pa) + amd_pkg::TA_W'(top_sel.pa);
      num[0]   = amd_pkg::TC_W'(pair_ff.pr) + amd_pkg::TC_W'(top_sel.pr)
                 + amd_pkg::TC_W'(ta >> 1);
      num[1]   = amd_pkg::TC_W'(pair_ff.pg) + amd_pkg::TC_W'(top_sel.pg)
                 + amd_pkg::TC_W'(ta >> 1);
      num[2]   = amd_pkg::TC_W'(pair_ff.pb) + amd_pkg::TC_W'(top_sel.pb)
                 + amd_pkg::TC_W'(ta >> 1);
      ta_round = ta + amd_pkg::TA_W'(2);
   end

   // Sequencer: next state and strobes
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      div_start  = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         amd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = amd_pkg::ST_PAIR;
            end
         end
         amd_pkg::ST_PAIR: begin
            ram_we = job_ff == amd_pkg::JOB_WRITE;
            ram_re = job_ff == amd_pkg::JOB_READ;
            if (job_ff == amd_pkg::JOB_READ || job_ff == amd_pkg::JOB_DIRECT) begin
               state_in = amd_pkg::ST_MERGE;
            end else begin
               state_in = amd_pkg::ST_IDLE;
            end
         end
         amd_pkg::ST_MERGE: begin
            div_start = 1'b1;
            state_in  = amd_pkg::ST_DIV;
         end
         amd_pkg::ST_DIV: begin
            if (div_stat.done && (!rsp_valid_ff || rsp_tready)) begin
               load_out = 1'b1;
               state_in = amd_pkg::ST_IDLE;
            end
         end
         default: state_in = amd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= amd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Registers, counters and held pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= amd_pkg::RESET_WIDTH;
         height_ff <= amd_pkg::RESET_HEIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
         held_ff   <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            amd_pkg::REG_WIDTH:  width_ff  <= csr_pwdata[WW-1:0];
            amd_pkg::REG_HEIGHT: height_ff <= csr_pwdata[HW-1:0];
            default:             width_ff  <= width_ff;
         endcase
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= x_nxt;
         row_ff <= y_nxt;
         if (capture) begin
            held_ff <= amd_pkg::pixel_type'(req_tdata);
         end
      end
   end

   // Job payload
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff  <= amd_pkg::pixel_type'(req_tdata);
         w1_ff   <= w_is_one;
         addr_ff <= ox_ext[ADDR_W-1:0];
         last_ff <= last_in;
      end
      if (state_ff == amd_pkg::ST_PAIR) begin
         pair_ff <= pair_cur;
      end
      if (div_start) begin
         zero_ff  <= ta == '0;
         alpha_ff <= ta_round[amd_pkg::TA_W-1:2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff <= amd_pkg::JOB_NONE;
      end else if (accept) begin
         job_ff <= job_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff.r <= zero_ff ? '0 : quo[0];
         rsp_data_ff.g <= zero_ff ? '0 : quo[1];
         rsp_data_ff.b <= zero_ff ? '0 : quo[2];
         rsp_data_ff.a <= alpha_ff;
         rsp_last_ff   <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Line store of top-row pair sums
   amd_ram #(
      .DATA_W (amd_pkg::ENTRY_W),
      .DEPTH  (DEPTH)
   ) u_line_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (addr_ff),
      .wdata (pair_cur),
      .rdata (ram_rdata)
   );

   // Shared quotient unit for the three colour channels
   amd_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num_in (num),
      .den_in (ta),
      .quo    (quo),
      .stat   (div_stat)
   );

   // Checks
   a_busy_in_div : assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == amd_pkg::ST_DIV)
      else $error("quotient unit busy outside division state");

   a_ram_one_op : assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("line store read and written in one cycle");

   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("second pixel taken while one is in flight");

   a_load_done : assert property (@(posedge clock) disable iff (reset)
      load_out |-> div_stat.done && !div_stat.busy)
      else $error("output loaded before division finished");

endmodule

// ===== hw/rtl/amd_ram.sv =====
module amd_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [DATA_W-1:0]                        wdata,
   output logic [DATA_W-1:0]                        rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // Single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/amd_div.sv =====
module amd_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [2:0][amd_pkg::TC_W-1:0]          num_in,
   input  logic [amd_pkg::TA_W-1:0]               den_in,
   output logic [2:0][amd_pkg::PIX_W-1:0]         quo,
   output amd_pkg::div_stat_type                  stat
);

   localparam int STEPS = amd_pkg::PIX_W;
   localparam int CNT_W = $clog2(STEPS);

   logic [2:0][amd_pkg::TC_W-1:0]  rem_ff, rem_in;
   logic [amd_pkg::TC_W-1:0]       dsh_ff;
   logic [2:0][amd_pkg::PIX_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]               cnt_ff;
   logic                           busy_ff;
   logic                           done_ff;
   logic [2:0]                     ge;

   // One quotient bit per cycle for each of the three channels
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ge[i]     = rem_ff[i] >= dsh_ff;
         rem_in[i] = ge[i] ? (rem_ff[i] - dsh_ff) : rem_ff[i];
         quo_in[i] = {quo_ff[i][amd_pkg::PIX_W-2:0], ge[i]};
      end
   end

   // Datapath: divisor starts at its top quotient weight and shifts down
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num_in;
         dsh_ff <= amd_pkg::TC_W'({den_in, {(STEPS-1){1'b0}}});
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         dsh_ff <= dsh_ff >> 1;
      end
   end

   // Step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(STEPS-1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign quo       = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
